// ===== rtl/vdrc_pkg.sv =====
// shared types, register indexes, reset values and event codes of the disconnect controller
`timescale 1ns / 1ps
package vdrc_pkg;

	localparam int LEVEL_W    = 12;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_DISC  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_DISC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_RECON = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_RECON = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_DELAY = 3'd4;

	localparam logic [LEVEL_W-1:0] RST_LOW_DISC   = 12'd1150;
	localparam logic [LEVEL_W-1:0] RST_HIGH_DISC  = 12'd1450;
	localparam logic [LEVEL_W-1:0] RST_LOW_RECON  = 12'd1250;
	localparam logic [LEVEL_W-1:0] RST_HIGH_RECON = 12'd1400;
	localparam logic [TIME_W-1:0]  RST_FAULT_DELAY = 32'd5000;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_FAULT_START = 3'd1,
		EV_TRIP        = 3'd2,
		EV_FAULT_CLEAR = 3'd3,
		EV_RECONNECT   = 3'd4
	} event_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] low_disc;
		logic [LEVEL_W-1:0] high_disc;
		logic [LEVEL_W-1:0] low_recon;
		logic [LEVEL_W-1:0] high_recon;
		logic [TIME_W-1:0]  fault_delay;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  now_time;
		logic [LEVEL_W-1:0] output_level;
		logic [LEVEL_W-1:0] battery_level;
		logic [LEVEL_W-1:0] supply_level;
	} sample_t;

	typedef struct packed {
		logic              relay_closed;
		logic              alarm_active;
		logic [TIME_W-1:0] alarm_begin;
	} state_t;

	typedef struct packed {
		logic   relay_closed_now;
		logic   set_pulse;
		logic   reset_pulse;
		logic   fault_pending;
		event_t event_code;
	} result_t;

endpackage

// ===== rtl/vdrc_cfg_regs.sv =====
// configuration register file of the disconnect controller
`timescale 1ns / 1ps
module vdrc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [vdrc_pkg::CFG_IDX_W-1:0]     index,
	input  logic [vdrc_pkg::CFG_DATA_W-1:0]    data,
	output vdrc_pkg::cfg_t                     cfg
);
	import vdrc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_disc    <= RST_LOW_DISC;
			cfg_q.high_disc   <= RST_HIGH_DISC;
			cfg_q.low_recon   <= RST_LOW_RECON;
			cfg_q.high_recon  <= RST_HIGH_RECON;
			cfg_q.fault_delay <= RST_FAULT_DELAY;
		end else if (wr_en) begin
			unique case (index)
				REG_LOW_DISC:    cfg_q.low_disc    <= data[LEVEL_W-1:0];
				REG_HIGH_DISC:   cfg_q.high_disc   <= data[LEVEL_W-1:0];
				REG_LOW_RECON:   cfg_q.low_recon   <= data[LEVEL_W-1:0];
				REG_HIGH_RECON:  cfg_q.high_recon  <= data[LEVEL_W-1:0];
				REG_FAULT_DELAY: cfg_q.fault_delay <= data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/vdrc_core.sv =====
// per-sample decision logic: fault timing, trip, clear and reconnect
`timescale 1ns / 1ps
module vdrc_core (
	input  vdrc_pkg::cfg_t    cfg,
	input  vdrc_pkg::sample_t smp,
	input  vdrc_pkg::state_t  st,
	output vdrc_pkg::state_t  st_nxt,
	output vdrc_pkg::result_t res
);
	import vdrc_pkg::*;

	logic               fault;
	logic               in_window;
	logic [TIME_W-1:0]  elapsed;
	logic [LEVEL_W-1:0] vmin;
	logic [LEVEL_W-1:0] vmax;
	logic               set_p;
	logic               rst_p;
	event_t             ev;

	assign fault     = (smp.output_level < cfg.low_disc) || (smp.output_level > cfg.high_disc);
	assign in_window = (smp.output_level > cfg.low_disc) && (smp.output_level < cfg.high_disc);
	assign elapsed   = smp.now_time - st.alarm_begin;
	assign vmin      = (smp.battery_level < smp.supply_level) ? smp.battery_level
	                                                          : smp.supply_level;
	assign vmax      = (smp.battery_level > smp.supply_level) ? smp.battery_level
	                                                          : smp.supply_level;

	always_comb begin
		st_nxt = st;
		set_p  = 1'b0;
		rst_p  = 1'b0;
		ev     = EV_NONE;
		if (st.relay_closed) begin
			if (fault) begin
				if (!st.alarm_active) begin
					st_nxt.alarm_active = 1'b1;
					st_nxt.alarm_begin  = smp.now_time;
					ev = EV_FAULT_START;
				end else if (elapsed > cfg.fault_delay) begin
					st_nxt.relay_closed = 1'b0;
					st_nxt.alarm_active = 1'b0;
					st_nxt.alarm_begin  = '0;
					rst_p = 1'b1;
					ev = EV_TRIP;
				end
			end else if (in_window && st.alarm_active) begin
				st_nxt.alarm_active = 1'b0;
				st_nxt.alarm_begin  = '0;
				ev = EV_FAULT_CLEAR;
			end
		end else if ((vmax > cfg.low_recon) && (vmin < cfg.high_recon)) begin
			st_nxt.relay_closed = 1'b1;
			set_p = 1'b1;
			ev = EV_RECONNECT;
		end
	end

	assign res.relay_closed_now = st_nxt.relay_closed;
	assign res.set_pulse        = set_p;
	assign res.reset_pulse      = rst_p;
	assign res.fault_pending    = st_nxt.alarm_active;
	assign res.event_code       = ev;

endmodule

// ===== rtl/voltage_disconnect_relay_control.sv =====
// top level of the low-voltage disconnect relay controller
//
//   channel  handshake            payload
//   in       in_valid / in_ready  now_time, output_level, battery_level, supply_level
//   out      out_valid/ out_ready relay_closed_now, set_pulse, reset_pulse,
//                                 fault_pending, event_code
//   cfg      cfg_wr_en            cfg_index, cfg_data
//
// one item per cycle sustained while out_ready is high; a result is offered once its item
// has passed the input register and then the result register
// reset opens the relay, clears any pending fault and loads the default thresholds
// when out_ready is low the result holds, the input stage holds behind it and
// in_ready drops only once both stages are full
`timescale 1ns / 1ps
module voltage_disconnect_relay_control (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [vdrc_pkg::TIME_W-1:0]     now_time,
	input  logic [vdrc_pkg::LEVEL_W-1:0]    output_level,
	input  logic [vdrc_pkg::LEVEL_W-1:0]    battery_level,
	input  logic [vdrc_pkg::LEVEL_W-1:0]    supply_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            relay_closed_now,
	output logic                            set_pulse,
	output logic                            reset_pulse,
	output logic                            fault_pending,
	output logic [2:0]                      event_code,
	input  logic                            cfg_wr_en,
	input  logic [vdrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vdrc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import vdrc_pkg::*;

	cfg_t    cfg;
	sample_t smp_s1;
	logic    vld_s1;
	result_t res_s2;
	logic    vld_s2;
	state_t  st_q;
	state_t  st_nxt;
	result_t res;
	logic    in_acc;
	logic    adv_s1;

	vdrc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	vdrc_core u_core (
		.cfg    (cfg),
		.smp    (smp_s1),
		.st     (st_q),
		.st_nxt (st_nxt),
		.res    (res)
	);

	assign adv_s1   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			st_q   <= '0;
		end else begin
			vld_s1 <= in_acc || (vld_s1 && !adv_s1);
			vld_s2 <= adv_s1 || (vld_s2 && !out_ready);
			if (adv_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_s1.now_time      <= now_time;
			smp_s1.output_level  <= output_level;
			smp_s1.battery_level <= battery_level;
			smp_s1.supply_level  <= supply_level;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = vld_s2;
	assign relay_closed_now = res_s2.relay_closed_now;
	assign set_pulse        = res_s2.set_pulse;
	assign reset_pulse      = res_s2.reset_pulse;
	assign fault_pending    = res_s2.fault_pending;
	assign event_code       = res_s2.event_code;

`ifndef SYNTHESIS
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(set_pulse && reset_pulse))
		else $error("set and reset pulse together");

	a_trip_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reset_pulse) |-> (!relay_closed_now && !fault_pending))
		else $error("trip left relay closed or fault pending");

	a_set_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && set_pulse) |-> (relay_closed_now && !fault_pending))
		else $error("reconnect without closed relay");

	a_state_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (st_q.relay_closed == res_s2.relay_closed_now
			&& st_q.alarm_active == res_s2.fault_pending))
		else $error("state register out of step with result");
`endif

endmodule
